// ----- design/bmhq_pkg.sv -----
`timescale 1ns / 1ps

package bmhq_pkg;

	localparam int HEAP_DEPTH = 256;
	localparam int ADDR_W     = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int KID_W      = ADDR_W + 2;
	localparam int ENTRY_W    = 9;

	localparam logic FN_PUSH = 1'b0;
	localparam logic FN_POP  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic               func;
		logic signed [31:0] value;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0]  top_value;
		logic [ENTRY_W-1:0]  entry_count;
		logic                is_empty;
		logic [1:0]          status;
	} out_word_t;

	typedef enum logic [1:0] {
		RD_PARENT,
		RD_LEFT,
		RD_RIGHT,
		RD_LAST
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_VAL,
		WR_PARENT,
		WR_CHILD
	} wr_sel_t;

	typedef struct packed {
		logic    accept;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    pos_up;
		logic    pos_dn;
		logic    lat_left;
		logic    lat_val;
	} cmd_t;

	typedef struct packed {
		logic is_pop;
		logic full;
		logic empty;
		logic last_one;
		logic pos_root;
		logic up_swap;
		logic dn_leaf;
		logic dn_swap;
	} sts_t;

endpackage

// ----- design/bmhq_dp.sv -----
`timescale 1ns / 1ps

module bmhq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  bmhq_pkg::in_word_t  in_word,
	input  bmhq_pkg::cmd_t      cmd,
	output bmhq_pkg::sts_t      sts,
	output bmhq_pkg::out_word_t out_word
);

	logic signed [31:0] mem [bmhq_pkg::HEAP_DEPTH];

	logic [bmhq_pkg::CNT_W-1:0]  count_q;
	logic [1:0]                  status_q;
	logic [bmhq_pkg::ADDR_W-1:0] pos_q;
	logic signed [31:0]          val_q;
	logic signed [31:0]          left_q;
	logic signed [31:0]          root_q;
	logic signed [31:0]          rdata_q;

	logic [bmhq_pkg::ADDR_W-1:0] parent;
	logic [bmhq_pkg::KID_W-1:0]  kid_l;
	logic [bmhq_pkg::KID_W-1:0]  kid_r;
	logic [bmhq_pkg::KID_W-1:0]  cnt_ext;
	logic [bmhq_pkg::CNT_W-1:0]  cnt_m1;
	logic                        take_r;
	logic signed [31:0]          child;
	logic [bmhq_pkg::ADDR_W-1:0] kid_sel;
	logic [bmhq_pkg::ADDR_W-1:0] raddr;
	logic                        wr_en;
	logic signed [31:0]          wdata;

	assign parent  = (pos_q - 1'b1) >> 1;
	assign kid_l   = bmhq_pkg::KID_W'({pos_q, 1'b1});
	assign kid_r   = kid_l + bmhq_pkg::KID_W'(1);
	assign cnt_ext = bmhq_pkg::KID_W'(count_q);
	assign cnt_m1  = count_q - 1'b1;
	assign take_r  = (kid_r < cnt_ext) && (rdata_q > left_q);
	assign child   = take_r ? rdata_q : left_q;
	assign kid_sel = take_r ? kid_r[bmhq_pkg::ADDR_W-1:0] : kid_l[bmhq_pkg::ADDR_W-1:0];

	always_comb begin
		case (cmd.rd_sel)
			bmhq_pkg::RD_PARENT: raddr = parent;
			bmhq_pkg::RD_LEFT:   raddr = kid_l[bmhq_pkg::ADDR_W-1:0];
			bmhq_pkg::RD_RIGHT:  raddr = kid_r[bmhq_pkg::ADDR_W-1:0];
			bmhq_pkg::RD_LAST:   raddr = cnt_m1[bmhq_pkg::ADDR_W-1:0];
			default:             raddr = parent;
		endcase
	end

	always_comb begin
		wr_en = 1'b1;
		case (cmd.wr_sel)
			bmhq_pkg::WR_VAL:    wdata = val_q;
			bmhq_pkg::WR_PARENT: wdata = rdata_q;
			bmhq_pkg::WR_CHILD:  wdata = child;
			default: begin
				wdata = val_q;
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pos_q] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			status_q <= bmhq_pkg::ST_OK;
		end else if (cmd.accept) begin
			if (in_word.func == bmhq_pkg::FN_PUSH) begin
				if (sts.full) begin
					status_q <= bmhq_pkg::ST_FULL;
				end else begin
					status_q <= bmhq_pkg::ST_OK;
					count_q  <= count_q + 1'b1;
				end
			end else begin
				if (sts.empty) begin
					status_q <= bmhq_pkg::ST_EMPTY;
				end else begin
					status_q <= bmhq_pkg::ST_OK;
					count_q  <= cnt_m1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q <= in_word.value;
			if (in_word.func == bmhq_pkg::FN_PUSH) begin
				pos_q <= count_q[bmhq_pkg::ADDR_W-1:0];
			end else begin
				pos_q <= '0;
			end
		end else if (cmd.pos_up) begin
			pos_q <= parent;
		end else if (cmd.pos_dn) begin
			pos_q <= kid_sel;
		end
		if (cmd.lat_val) begin
			val_q <= rdata_q;
		end
		if (cmd.lat_left) begin
			left_q <= rdata_q;
		end
		if (wr_en && (pos_q == '0)) begin
			root_q <= wdata;
		end
	end

	assign sts.is_pop   = (in_word.func == bmhq_pkg::FN_POP);
	assign sts.full     = (count_q == bmhq_pkg::CNT_W'(bmhq_pkg::HEAP_DEPTH));
	assign sts.empty    = (count_q == '0);
	assign sts.last_one = (count_q == bmhq_pkg::CNT_W'(1));
	assign sts.pos_root = (pos_q == '0);
	assign sts.up_swap  = (val_q > rdata_q);
	assign sts.dn_leaf  = (kid_l >= cnt_ext);
	assign sts.dn_swap  = (child > val_q);

	assign out_word.top_value   = (count_q != '0) ? root_q : 32'sd0;
	assign out_word.entry_count = bmhq_pkg::ENTRY_W'(count_q);
	assign out_word.is_empty    = (count_q == '0);
	assign out_word.status      = status_q;

endmodule

// ----- design/bmhq_ctrl.sv -----
`timescale 1ns / 1ps

module bmhq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  bmhq_pkg::sts_t sts,
	output bmhq_pkg::cmd_t cmd,
	output logic           busy,
	output logic           done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_DN_LAST,
		S_DN_CHK,
		S_DN_RDR,
		S_DN_PICK
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;
	logic   fin;

	always_comb begin
		cmd     = '0;
		cmd.rd_sel = bmhq_pkg::RD_PARENT;
		cmd.wr_sel = bmhq_pkg::WR_NONE;
		state_d = state_q;
		fin     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (!sts.is_pop && !sts.full) begin
						state_d = S_UP_CHK;
					end else if (sts.is_pop && !sts.empty && !sts.last_one) begin
						cmd.rd_sel = bmhq_pkg::RD_LAST;
						state_d    = S_DN_LAST;
					end else begin
						fin = 1'b1;
					end
				end
			end
			S_UP_CHK: begin
				if (sts.pos_root) begin
					cmd.wr_sel = bmhq_pkg::WR_VAL;
					state_d    = S_IDLE;
					fin        = 1'b1;
				end else begin
					cmd.rd_sel = bmhq_pkg::RD_PARENT;
					state_d    = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (sts.up_swap) begin
					cmd.wr_sel = bmhq_pkg::WR_PARENT;
					cmd.pos_up = 1'b1;
					state_d    = S_UP_CHK;
				end else begin
					cmd.wr_sel = bmhq_pkg::WR_VAL;
					state_d    = S_IDLE;
					fin        = 1'b1;
				end
			end
			S_DN_LAST: begin
				cmd.lat_val = 1'b1;
				state_d     = S_DN_CHK;
			end
			S_DN_CHK: begin
				if (sts.dn_leaf) begin
					cmd.wr_sel = bmhq_pkg::WR_VAL;
					state_d    = S_IDLE;
					fin        = 1'b1;
				end else begin
					cmd.rd_sel = bmhq_pkg::RD_LEFT;
					state_d    = S_DN_RDR;
				end
			end
			S_DN_RDR: begin
				cmd.rd_sel   = bmhq_pkg::RD_RIGHT;
				cmd.lat_left = 1'b1;
				state_d      = S_DN_PICK;
			end
			S_DN_PICK: begin
				if (sts.dn_swap) begin
					cmd.wr_sel = bmhq_pkg::WR_CHILD;
					cmd.pos_dn = 1'b1;
					state_d    = S_DN_CHK;
				end else begin
					cmd.wr_sel = bmhq_pkg::WR_VAL;
					state_d    = S_IDLE;
					fin        = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
			done_q  <= fin;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// ----- design/binary_max_heap_queue.sv -----
`timescale 1ns / 1ps

// channel   ports                      handshake
// input     in_word (func, value)      taken when start && !busy
// result    out_word (top, count, ...) one cycle, marked by done
//
// a push puts the value at the end and moves it up while it beats its parent, until it
// reaches the root or stops below; a pop moves the last value to the root and down while
// the larger child beats it, until it ends on a leaf or stops; the value moves at most
// 8 levels for a push and 7 for a pop at 256 entries; refused words and a pop of the
// last entry walk no levels; one heap read and at most one write per cycle
// reset clears the count and control; the receiver cannot stall

module binary_max_heap_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bmhq_pkg::in_word_t  in_word,
	output logic                busy,
	output logic                done,
	output bmhq_pkg::out_word_t out_word
);

	bmhq_pkg::cmd_t cmd;
	bmhq_pkg::sts_t sts;

	bmhq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bmhq_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.cmd      (cmd),
		.sts      (sts),
		.out_word (out_word)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while busy");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_word.is_empty == (out_word.entry_count == '0)))
		else $error("empty flag disagrees with count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_word.entry_count <= bmhq_pkg::ENTRY_W'(bmhq_pkg::HEAP_DEPTH)))
		else $error("count beyond depth");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_word.is_empty) |-> (out_word.top_value == 32'sd0))
		else $error("nonzero top on empty heap");

endmodule

// ----- tb/binary_max_heap_queue_tb.sv -----
`timescale 1ns / 1ps

module binary_max_heap_queue_tb;

	localparam int CLK_HI      = 6;
	localparam int CLK_LO      = 6;
	localparam int RESET_CYC   = 6;
	localparam int SETTLE_CYC  = 30;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 600;

	class heap_scoreboard;
		logic signed [31:0]  heap_vals [bmhq_pkg::HEAP_DEPTH];
		int unsigned         fill;
		bmhq_pkg::out_word_t expected_q [$];
		int                  errors;

		function new();
			fill   = 0;
			errors = 0;
		endfunction

		function void swap_vals(int unsigned a, int unsigned b);
			logic signed [31:0] tmp;
			tmp          = heap_vals[a];
			heap_vals[a] = heap_vals[b];
			heap_vals[b] = tmp;
		endfunction

		// predicts the result of one accepted word and queues it
		function void note_word(bmhq_pkg::in_word_t w);
			int unsigned         pos;
			int unsigned         up;
			int unsigned         kid;
			bmhq_pkg::out_word_t r;
			r.status = bmhq_pkg::ST_OK;
			if (w.func == bmhq_pkg::FN_PUSH) begin
				if (fill >= bmhq_pkg::HEAP_DEPTH) begin
					r.status = bmhq_pkg::ST_FULL;
				end else begin
					heap_vals[fill] = w.value;
					pos = fill;
					fill++;
					while (pos > 0) begin
						up = (pos - 1) / 2;
						if (!(heap_vals[pos] > heap_vals[up]))
							break;
						swap_vals(pos, up);
						pos = up;
					end
				end
			end else begin
				if (fill == 0) begin
					r.status = bmhq_pkg::ST_EMPTY;
				end else begin
					swap_vals(0, fill - 1);
					fill--;
					pos = 0;
					while (2 * pos + 1 < fill) begin
						kid = 2 * pos + 1;
						// left child wins a tie
						if (kid + 1 < fill && heap_vals[kid + 1] > heap_vals[kid])
							kid++;
						if (!(heap_vals[kid] > heap_vals[pos]))
							break;
						swap_vals(kid, pos);
						pos = kid;
					end
				end
			end
			r.top_value   = (fill > 0) ? heap_vals[0] : 32'sd0;
			r.entry_count = fill[bmhq_pkg::ENTRY_W-1:0];
			r.is_empty    = (fill == 0);
			expected_q.push_back(r);
		endfunction

		function void compare_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(bmhq_pkg::out_word_t r);
			bmhq_pkg::out_word_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, got %0h", $time, r);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			compare_field("top_value", e.top_value, r.top_value);
			compare_field("entry_count", e.entry_count, r.entry_count);
			compare_field("is_empty", e.is_empty, r.is_empty);
			compare_field("status", e.status, r.status);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	bmhq_pkg::in_word_t  in_word;
	logic                busy;
	logic                done;
	bmhq_pkg::out_word_t out_word;

	heap_scoreboard sb;
	int             idle_pct;
	int             rand_sent;
	int             cycles;

	binary_max_heap_queue i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.in_word  (in_word),
		.busy     (busy),
		.done     (done),
		.out_word (out_word)
	);

	initial begin
		clk = 1'b0;
		sb  = new();
	end

	always begin
		#CLK_LO clk = 1'b1;
		#CLK_HI clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result check first, then note the word taken at this edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(out_word);
			if (start && !busy)
				sb.note_word(in_word);
		end
	end

	task automatic send_word(logic fn, logic signed [31:0] v);
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start         = 1'b1;
		in_word.func  = fn;
		in_word.value = v;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start = 1'b0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $signed($urandom_range(0, 15)) - 8;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random(int push_pct);
		idle_pct = (rand_sent < RAND_ITEMS / 3) ? 37 :
			(rand_sent < 2 * RAND_ITEMS / 3) ? 59 : 0;
		if ($urandom_range(0, 99) < push_pct)
			send_word(bmhq_pkg::FN_PUSH, pick_value());
		else
			send_word(bmhq_pkg::FN_POP, $urandom);
		rand_sent++;
	endtask

	initial begin
		cycles    = 0;
		rand_sent = 0;
		idle_pct  = 37;
		arst_n    = 1'b0;
		start     = 1'b0;
		in_word   = '0;
		repeat (RESET_CYC) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty pops, extremes, ties, drain to empty
		send_word(bmhq_pkg::FN_POP, 32'sd0);
		send_word(bmhq_pkg::FN_POP, -32'sd1);
		send_word(bmhq_pkg::FN_PUSH, 32'sd0);
		send_word(bmhq_pkg::FN_PUSH, 32'sh7fffffff);
		send_word(bmhq_pkg::FN_PUSH, 32'sh80000000);
		send_word(bmhq_pkg::FN_PUSH, -32'sd1);
		send_word(bmhq_pkg::FN_PUSH, 32'sd5);
		send_word(bmhq_pkg::FN_PUSH, 32'sd5);
		send_word(bmhq_pkg::FN_PUSH, 32'sd5);
		send_word(bmhq_pkg::FN_PUSH, 32'sh7fffffff);
		send_word(bmhq_pkg::FN_PUSH, 32'sd1);
		repeat (9) send_word(bmhq_pkg::FN_POP, 32'sh55aa55aa);
		send_word(bmhq_pkg::FN_POP, 32'sh7fffffff);
		send_word(bmhq_pkg::FN_PUSH, 32'sh80000000);
		send_word(bmhq_pkg::FN_POP, 32'sd0);
		wait_drained();

		// fill to capacity, then pushes while full
		while (sb.fill < bmhq_pkg::HEAP_DEPTH)
			send_random(95);
		repeat (4) send_word(bmhq_pkg::FN_PUSH, pick_value());
		wait_drained();

		// drain to empty, then pops while empty
		while (sb.fill > 0)
			send_random(5);
		repeat (3) send_word(bmhq_pkg::FN_POP, $urandom);
		wait_drained();

		while (rand_sent < RAND_ITEMS)
			send_random(50);
		wait_drained();
		repeat (SETTLE_CYC) @(negedge clk);

		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
